// ----- rtl/cpra_pkg.sv -----
`timescale 1ns / 1ps

package cpra_pkg;

   // Field widths of the request and response.
   localparam int CMD_W   = 2;
   localparam int COUNT_W = 7;
   localparam int START_W = 6;

   // Default size of the page table.
   localparam int TABLE_PAGES_DEF = 64;

   // Command codes.
   localparam logic [CMD_W-1:0] CMD_ALLOC    = 2'd0;
   localparam logic [CMD_W-1:0] CMD_FREE     = 2'd1;
   localparam logic [CMD_W-1:0] CMD_FREE_ALL = 2'd2;

   // One request.
   typedef struct packed {
      logic [CMD_W-1:0]   cmd;
      logic [COUNT_W-1:0] count;
      logic               from_end;
      logic [START_W-1:0] start_page;
   } req_type;

   // One response.
   typedef struct packed {
      logic               ok;
      logic [START_W-1:0] first_page;
   } rsp_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic capture;    // register the accepted request
      logic load_scan;  // set the pointer to the first page of the search
      logic scan_step;  // move the search one page on
      logic load_mark;  // a run was found: point at its start
      logic mark_step;  // mark the page at the pointer valid and advance
      logic load_free;  // point at the first page to free
      logic free_step;  // clear the page at the pointer and advance
      logic load_clear; // point at page 0 to clear the whole table
      logic finish;     // register the response
      logic fin_ok;     // response ok flag
      logic fin_first;  // response carries the run start
   } dp_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic [CMD_W-1:0] cmd;
      logic             len_bad;     // allocation length is zero or too large
      logic             free_empty;  // free request touches no page
      logic             run_hit;     // the current page completes a free run
      logic             scan_last;   // the current page is the last one to search
      logic             rem_last;    // one page left to mark or free
      logic             ptr_last;    // pointer is at the top page
   } dp_sts_type;

endpackage

// ----- rtl/contiguous_page_run_allocator_top.sv -----
`timescale 1ns / 1ps

// Contiguous page-run allocator: one valid bit per page, first-fit run search.
// Requests enter on req_item and are taken at a rising edge where start is high
// and busy is low. busy stays high until the request is finished.
// Each request gives exactly one response: rsp_valid is high for one cycle with
// rsp_item (ok flag and first page of an allocated run). The receiver cannot
// stall; a response must be taken in the cycle it is shown.
// Steps from the accepted request to the response strobe:
//   unknown command, rejected length or empty free: answered from decode.
//   free of n pages: walks the n pages, stopping at the top page.
//   free-all: walks every page of the table.
//   allocate: searches for a run, then marks its pages on success; on failure
//   the search walks on to the last page in its direction.
// The search, the marking and the clearing walk the page table one page per
// cycle through a single pointer. A new request may be given in the cycle the
// response is shown.
// Synchronous reset puts the controller into its clearing state; once reset is
// released the block stays busy while it clears the table page by page.

module contiguous_page_run_allocator_top
   import cpra_pkg::*;
#(
   parameter int TABLE_PAGES = TABLE_PAGES_DEF
)
(
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req_item,
   output logic    rsp_valid,
   output rsp_type rsp_item
);

   dp_cmd_type dp_cmd;
   dp_sts_type dp_sts;

   // Sequencer for the request.
   cpra_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .rsp_valid (rsp_valid),
      .sts       (dp_sts),
      .cmd       (dp_cmd)
   );

   // Page table and walk registers.
   cpra_dp #(
      .TABLE_PAGES (TABLE_PAGES)
   ) u_dp (
      .clock    (clock),
      .reset    (reset),
      .req_item (req_item),
      .cmd      (dp_cmd),
      .sts      (dp_sts),
      .rsp_item (rsp_item)
   );

endmodule

// ----- rtl/cpra_ctrl.sv -----
`timescale 1ns / 1ps

module cpra_ctrl
   import cpra_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       start,
   output logic       busy,
   output logic       rsp_valid,
   input  dp_sts_type sts,
   output dp_cmd_type cmd
);

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_DECODE = 3'd1;
   localparam logic [2:0] ST_SCAN   = 3'd2;
   localparam logic [2:0] ST_MARK   = 3'd3;
   localparam logic [2:0] ST_FREE   = 3'd4;
   localparam logic [2:0] ST_CLEAR  = 3'd5;
   localparam logic [2:0] ST_INIT   = 3'd6;

   logic [2:0] state_ff;
   logic [2:0] state_in;
   logic       rsp_valid_ff;
   logic       rsp_valid_in;

   assign busy      = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   // Next state and datapath commands.
   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = 1'b0;
      cmd          = '0;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd.capture = 1'b1;
               state_in    = ST_DECODE;
            end
         end
         ST_DECODE: begin
            case (sts.cmd)
               CMD_ALLOC: begin
                  if (sts.len_bad) begin
                     cmd.finish   = 1'b1;
                     rsp_valid_in = 1'b1;
                     state_in     = ST_IDLE;
                  end else begin
                     cmd.load_scan = 1'b1;
                     state_in      = ST_SCAN;
                  end
               end
               CMD_FREE: begin
                  if (sts.free_empty) begin
                     cmd.finish   = 1'b1;
                     cmd.fin_ok   = 1'b1;
                     rsp_valid_in = 1'b1;
                     state_in     = ST_IDLE;
                  end else begin
                     cmd.load_free = 1'b1;
                     state_in      = ST_FREE;
                  end
               end
               CMD_FREE_ALL: begin
                  cmd.load_clear = 1'b1;
                  state_in       = ST_CLEAR;
               end
               default: begin
                  // Unknown command: answer with a failure and change nothing.
                  cmd.finish   = 1'b1;
                  rsp_valid_in = 1'b1;
                  state_in     = ST_IDLE;
               end
            endcase
         end
         ST_SCAN: begin
            if (sts.run_hit) begin
               cmd.load_mark = 1'b1;
               state_in      = ST_MARK;
            end else if (sts.scan_last) begin
               cmd.finish   = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end else begin
               cmd.scan_step = 1'b1;
            end
         end
         ST_MARK: begin
            cmd.mark_step = 1'b1;
            if (sts.rem_last) begin
               cmd.finish    = 1'b1;
               cmd.fin_ok    = 1'b1;
               cmd.fin_first = 1'b1;
               rsp_valid_in  = 1'b1;
               state_in      = ST_IDLE;
            end
         end
         ST_FREE: begin
            cmd.free_step = 1'b1;
            if (sts.rem_last || sts.ptr_last) begin
               cmd.finish   = 1'b1;
               cmd.fin_ok   = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         ST_CLEAR: begin
            // Free-all walks every page of the table and then answers.
            cmd.free_step = 1'b1;
            if (sts.ptr_last) begin
               cmd.finish   = 1'b1;
               cmd.fin_ok   = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         ST_INIT: begin
            // Clearing pass after reset; no response is given.
            cmd.free_step = 1'b1;
            if (sts.ptr_last) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // State and response strobe registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_INIT;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // The response strobe only appears once the controller is back at rest.
   a_rsp_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (state_ff == ST_IDLE))
      else $error("response strobe while a request is in progress");

   // An accepted request is always decoded next.
   a_accept_decode: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> (state_ff == ST_DECODE))
      else $error("accepted request not decoded");

   // A response never lasts more than one cycle.
   a_rsp_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |=> !rsp_valid_ff)
      else $error("response strobe held for two cycles");

endmodule

// ----- rtl/cpra_dp.sv -----
`timescale 1ns / 1ps

module cpra_dp
   import cpra_pkg::*;
#(
   parameter int TABLE_PAGES = TABLE_PAGES_DEF
)
(
   input  logic       clock,
   input  logic       reset,
   input  req_type    req_item,
   input  dp_cmd_type cmd,
   output dp_sts_type sts,
   output rsp_type    rsp_item
);

   localparam int PAGE_W = $clog2(TABLE_PAGES);
   localparam int PTR_W  = (PAGE_W + 1 > START_W + 1) ? PAGE_W + 1 : START_W + 1;
   localparam logic [PTR_W-1:0] PAGES = PTR_W'(TABLE_PAGES);
   localparam logic [PTR_W-1:0] TOP   = PTR_W'(TABLE_PAGES - 1);

   logic                   page_mem [TABLE_PAGES];
   logic                   rd_ff;
   req_type                req_ff;
   logic [PTR_W-1:0]       ptr_ff;
   logic [PTR_W-1:0]       ptr_in;
   logic [COUNT_W-1:0]     run_ff;
   logic [COUNT_W-1:0]     run_in;
   logic [COUNT_W-1:0]     rem_ff;
   logic [COUNT_W-1:0]     rem_in;
   logic [PTR_W-1:0]       first_ff;
   rsp_type                rsp_ff;

   logic [PTR_W-1:0]       count_ext;
   logic [COUNT_W-1:0]     run_inc;
   logic [PTR_W-1:0]       run_start;
   logic                   cur_free;
   logic [PAGE_W-1:0]      rd_addr;
   logic [PAGE_W-1:0]      wr_addr;

   assign count_ext = PTR_W'(req_ff.count);
   assign run_inc   = COUNT_W'(run_ff + 1'b1);
   assign cur_free  = ~rd_ff;

   // The table is read at the page the pointer moves to, so the bit is ready with it.
   assign rd_addr = ptr_in[PAGE_W-1:0];
   assign wr_addr = ptr_ff[PAGE_W-1:0];

   // Start of the run that ends at the pointer: upward it lies below, downward it is the pointer.
   assign run_start = req_ff.from_end ? ptr_ff : PTR_W'(ptr_ff - count_ext + 1'b1);

   // Status toward the controller.
   always_comb begin
      sts.cmd        = req_ff.cmd;
      sts.len_bad    = (req_ff.count == '0) || (count_ext > PAGES);
      sts.free_empty = (req_ff.count == '0) || (PTR_W'(req_ff.start_page) >= PAGES);
      sts.run_hit    = cur_free && (run_inc == req_ff.count);
      sts.scan_last  = req_ff.from_end ? (ptr_ff == '0) : (ptr_ff == TOP);
      sts.rem_last   = (rem_ff == COUNT_W'(1));
      sts.ptr_last   = (ptr_ff == TOP);
   end

   // Pointer, run length and remaining count.
   always_comb begin
      ptr_in = ptr_ff;
      run_in = run_ff;
      rem_in = rem_ff;
      if (cmd.load_scan) begin
         ptr_in = req_ff.from_end ? TOP : '0;
         run_in = '0;
      end else if (cmd.scan_step) begin
         ptr_in = req_ff.from_end ? PTR_W'(ptr_ff - 1'b1) : PTR_W'(ptr_ff + 1'b1);
         run_in = cur_free ? run_inc : '0;
      end else if (cmd.load_mark) begin
         ptr_in = run_start;
         rem_in = req_ff.count;
      end else if (cmd.load_free) begin
         ptr_in = PTR_W'(req_ff.start_page);
         rem_in = req_ff.count;
      end else if (cmd.load_clear) begin
         ptr_in = '0;
      end else if (cmd.mark_step || cmd.free_step) begin
         ptr_in = PTR_W'(ptr_ff + 1'b1);
         rem_in = COUNT_W'(rem_ff - 1'b1);
      end
   end

   // Page table: one valid bit per page, written at the pointer, read into a register.
   always_ff @(posedge clock) begin
      if (cmd.mark_step || cmd.free_step) begin
         page_mem[wr_addr] <= cmd.mark_step;
      end
      rd_ff <= page_mem[rd_addr];
   end

   // Working registers and response fields.
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         req_ff <= req_item;
      end
      if (reset) begin
         ptr_ff <= '0;
      end else begin
         ptr_ff <= ptr_in;
      end
      run_ff <= run_in;
      rem_ff <= rem_in;
      if (cmd.load_mark) begin
         first_ff <= run_start;
      end
      if (cmd.finish) begin
         rsp_ff.ok         <= cmd.fin_ok;
         rsp_ff.first_page <= cmd.fin_first ? first_ff[START_W-1:0] : '0;
      end
   end

   assign rsp_item = rsp_ff;

   // A run is only found on a page that reads as free.
   a_hit_free: assert property (@(posedge clock) disable iff (reset)
      cmd.load_mark |-> cur_free)
      else $error("run found on a page that is in use");

   // The pointer stays inside the table while it touches pages.
   a_ptr_range: assert property (@(posedge clock) disable iff (reset)
      (cmd.mark_step || cmd.free_step || cmd.scan_step) |-> (ptr_ff < PAGES))
      else $error("page pointer outside the table");

   // A found run lies wholly inside the table.
   a_run_in_table: assert property (@(posedge clock) disable iff (reset)
      cmd.load_mark |->
         ((PTR_W+1)'(run_start) + (PTR_W+1)'(count_ext) <= (PTR_W+1)'(PAGES)))
      else $error("found run runs past the top of the table");

endmodule

// ----- tb/sv/tb.sv -----
`timescale 1ns / 1ps

module tb;
   import cpra_pkg::*;

   localparam int PAGES         = TABLE_PAGES_DEF;
   localparam int RANDOM_ITEMS  = 900;
   // Longest response is a search over the whole table plus a full marking walk.
   localparam int SETTLE_CYCLES = 2 * PAGES + 16;

   // The fourth command code has no function and must be ignored.
   localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

   // Tracks the page map, predicts each response and checks what comes back.
   class page_run_scoreboard;
      logic [PAGES-1:0] page_used;
      rsp_type          pending_rsps [$];
      int unsigned      held_base [$];
      int unsigned      held_len [$];
      int               fail_count;

      function new();
         page_used  = '0;
         fail_count = 0;
      endfunction

      // Apply one request to the page map and return the response it yields.
      function rsp_type predict_response(req_type r);
         rsp_type     rsp;
         int unsigned len;
         int unsigned last;
         int unsigned base;
         int unsigned stop;
         int unsigned n;
         int unsigned k;
         bit          fits;
         rsp = '0;
         case (r.cmd)
            CMD_ALLOC: begin
               len = r.count;
               if (len != 0 && len <= PAGES) begin
                  last = PAGES - len;
                  // First fit over every start position, the last one included.
                  for (n = 0; n <= last; n++) begin
                     base = r.from_end ? (last - n) : n;
                     fits = 1'b1;
                     for (k = 0; k < len; k++) begin
                        if (page_used[base + k]) fits = 1'b0;
                     end
                     if (fits) begin
                        for (k = 0; k < len; k++) page_used[base + k] = 1'b1;
                        rsp.ok         = 1'b1;
                        rsp.first_page = base[START_W-1:0];
                        held_base.push_back(base);
                        held_len.push_back(len);
                        break;
                     end
                  end
               end
            end
            CMD_FREE: begin
               // The freed range is clipped at the top of the table.
               stop = r.start_page + r.count;
               if (stop > PAGES) stop = PAGES;
               for (n = r.start_page; n < stop; n++) page_used[n] = 1'b0;
               rsp.ok = 1'b1;
            end
            CMD_FREE_ALL: begin
               page_used = '0;
               held_base.delete();
               held_len.delete();
               rsp.ok = 1'b1;
            end
            default: begin
               rsp.ok = 1'b0;
            end
         endcase
         return rsp;
      endfunction

      function void note_request(req_type r);
         pending_rsps.push_back(predict_response(r));
      endfunction

      task report_mismatch(string msg);
         $display("MISMATCH at %0t ns: %s", $time, msg);
         fail_count++;
      endtask

      task check_response(rsp_type got);
         rsp_type want;
         if (pending_rsps.size() == 0) begin
            report_mismatch("response strobe with no request outstanding");
         end else begin
            want = pending_rsps.pop_front();
            if (got.ok !== want.ok)
               report_mismatch($sformatf("ok got %b want %b", got.ok, want.ok));
            if (got.first_page !== want.first_page)
               report_mismatch($sformatf("first_page got %0d want %0d",
                                         got.first_page, want.first_page));
         end
      endtask
   endclass

   logic    clock;
   logic    reset;
   logic    start;
   logic    busy;
   req_type req_item;
   logic    rsp_valid;
   rsp_type rsp_item;

   page_run_scoreboard sb;
   bit                 no_idle;

   contiguous_page_run_allocator_top #(
      .TABLE_PAGES(PAGES)
   ) u_top (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .busy     (busy),
      .req_item (req_item),
      .rsp_valid(rsp_valid),
      .rsp_item (rsp_item)
   );

   initial clock = 1'b0;
   always #5 clock = ~clock;

   // Responses are taken at the edge that ends their strobe cycle.
   always @(posedge clock) begin
      if (!reset && rsp_valid) sb.check_response(rsp_item);
   end

   function req_type make_req(logic [CMD_W-1:0] c, int unsigned n, bit fe, int unsigned sp);
      req_type r;
      r.cmd        = c;
      r.count      = n[COUNT_W-1:0];
      r.from_end   = fe;
      r.start_page = sp[START_W-1:0];
      return r;
   endfunction

   // Called at a falling edge; returns at the falling edge after acceptance.
   task issue_request(req_type r);
      int gap;
      gap = no_idle ? 0 : $urandom_range(0, 6);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_item <= r;
      start    <= 1'b1;
      do @(posedge clock); while (busy);
      sb.note_request(r);
      @(negedge clock);
   endtask

   function int unsigned pick_count();
      if ($urandom_range(0, 9) == 0) return $urandom_range(0, 127);
      return $urandom_range(1, 8);
   endfunction

   // Random mix: mostly allocations and frees of runs that are held, some noise.
   task run_random_requests();
      req_type     r;
      int unsigned roll;
      int unsigned idx;
      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         if (i % 150 == 0) no_idle = ($urandom_range(0, 2) == 0);
         roll = $urandom_range(0, 99);
         r = make_req(CMD_ALLOC, pick_count(), $urandom_range(0, 1), $urandom_range(0, 63));
         if (roll < 50) begin
            r.cmd = CMD_ALLOC;
         end else if (roll < 85) begin
            r.cmd = CMD_FREE;
            if (sb.held_base.size() != 0 && $urandom_range(0, 3) != 0) begin
               idx          = $urandom_range(0, sb.held_base.size() - 1);
               r.start_page = sb.held_base[idx][START_W-1:0];
               r.count      = sb.held_len[idx][COUNT_W-1:0];
               sb.held_base.delete(idx);
               sb.held_len.delete(idx);
            end
         end else if (roll < 90) begin
            r.cmd = CMD_FREE_ALL;
         end else if (roll < 95) begin
            r.cmd   = CMD_ALLOC;
            r.count = $urandom_range(0, 127);
         end else begin
            r.cmd = CMD_UNUSED;
         end
         issue_request(r);
      end
   endtask

   // Main sequence: reset, directed corner cases, random traffic, drain.
   initial begin
      sb       = new();
      no_idle  = 1'b0;
      reset    = 1'b1;
      start    = 1'b0;
      req_item = '0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // The last start position is reachable in both directions.
      issue_request(make_req(CMD_ALLOC, 1, 0, 0));
      issue_request(make_req(CMD_ALLOC, 63, 0, 0));
      issue_request(make_req(CMD_ALLOC, 1, 0, 0));
      issue_request(make_req(CMD_FREE, 64, 0, 0));
      issue_request(make_req(CMD_ALLOC, 1, 1, 0));
      issue_request(make_req(CMD_ALLOC, 63, 1, 0));
      issue_request(make_req(CMD_FREE_ALL, 0, 0, 0));
      // Whole-table run, then a free clipped at the top.
      issue_request(make_req(CMD_ALLOC, 64, 0, 63));
      issue_request(make_req(CMD_FREE, 127, 1, 60));
      issue_request(make_req(CMD_ALLOC, 4, 1, 0));
      issue_request(make_req(CMD_FREE, 0, 0, 63));
      // Rejected lengths and the unused command.
      issue_request(make_req(CMD_ALLOC, 0, 0, 0));
      issue_request(make_req(CMD_ALLOC, 65, 0, 0));
      issue_request(make_req(CMD_ALLOC, 127, 1, 63));
      issue_request(make_req(CMD_UNUSED, 127, 1, 63));
      issue_request(make_req(CMD_FREE, 20, 1, 10));
      issue_request(make_req(CMD_ALLOC, 20, 0, 0));
      issue_request(make_req(CMD_ALLOC, 1, 1, 0));
      issue_request(make_req(CMD_FREE_ALL, 127, 1, 63));
      issue_request(make_req(CMD_ALLOC, 64, 1, 0));
      issue_request(make_req(CMD_ALLOC, 1, 1, 0));
      issue_request(make_req(CMD_FREE_ALL, 0, 0, 0));

      run_random_requests();
      start <= 1'b0;

      // Drain every outstanding response, then watch for stray strobes.
      while (sb.pending_rsps.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (sb.fail_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

   // Hang guard, well beyond the slowest legal run.
   initial begin
      #5000000;
      $display("Test completed with failures");
      $finish;
   end

endmodule
